// ===== hw/rtl/llsw_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// llsw_pkg: shared types and constants of the line link stop-and-wait engine
// Event codes, parser phases, front-to-back command record.
// ----------------------------------------------------------------------------
package llsw_pkg;

    localparam int LINE_MAX      = 128;
    localparam int HISTORY_DEPTH = 8;
    localparam int HIST_W        = $clog2(HISTORY_DEPTH);
    localparam int FILL_W        = $clog2(HISTORY_DEPTH + 1);
    localparam int LCNT_W        = $clog2(LINE_MAX);

    localparam logic [2:0] EV_ACK       = 3'd0;
    localparam logic [2:0] EV_DATA      = 3'd1;
    localparam logic [2:0] EV_OWN_ACK   = 3'd2;
    localparam logic [2:0] EV_ACK_IGN   = 3'd3;
    localparam logic [2:0] EV_MALFORMED = 3'd4;
    localparam logic [2:0] EV_UNRECOG   = 3'd5;
    localparam logic [2:0] EV_OVERFLOW  = 3'd6;

    localparam logic [1:0] REG_SEND_INTERVAL = 2'd0;
    localparam logic [1:0] REG_ACK_TIMEOUT   = 2'd1;
    localparam logic [1:0] REG_MIN_ENERGY    = 2'd2;
    localparam logic [1:0] REG_FALL_THRESH   = 2'd3;

    typedef enum logic [3:0] {
        PH_START, PH_A, PH_DATA_P, PH_ALARM_P, PH_ACK_P, PH_ID, PH_ID_END,
        PH_PAYLOAD, PH_E_INT, PH_E_FR1, PH_E_FR2, PH_E_DONE, PH_ACK_ID,
        PH_ACK_END, PH_JUNK
    } t_phase;

    // command kinds handed from the front end to the back end
    typedef enum logic [2:0] {
        CMD_TICK, CMD_DATA_LINE, CMD_ACK_LINE, CMD_MALFORMED, CMD_UNRECOG,
        CMD_OVERFLOW
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind   kind;
        logic [31:0] id;
        logic        alarm;
        logic        has_energy;
        logic [15:0] energy;
        logic [13:0] local_energy;
    } t_cmd;

endpackage
`default_nettype wire

// ===== hw/rtl/llsw_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// llsw_front: byte parser
// Gathers bytes into lines, runs the prefix/id/energy parser, and hands
// one command per line end, overflow or tick to the back end.
// ----------------------------------------------------------------------------
module llsw_front import llsw_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic        i_req_type,
    input  wire logic [7:0]  i_rx_byte,
    input  wire logic [13:0] i_local_energy,
    output logic             o_cmd_valid,
    output t_cmd             o_cmd,
    input  wire logic        i_cmd_ready
);

    logic [LCNT_W-1:0] r_count, n_count;
    t_phase            r_phase, n_phase;
    logic [31:0]       r_id, n_id;
    logic [2:0]        r_tag, n_tag;
    logic [15:0]       r_energy, n_energy;
    logic              r_alarm, n_alarm;
    logic              r_cv;
    t_cmd              r_cmd, n_cmd;
    logic              n_emit;

    logic [7:0]  c;
    logic        dig;
    logic [3:0]  dv;
    logic [35:0] id_mul;
    logic [19:0] e_int;
    logic [16:0] e_add;

    assign o_ready     = !r_cv || i_cmd_ready;
    assign o_cmd_valid = r_cv;
    assign o_cmd       = r_cmd;

    function automatic logic [2:0] energy_search(logic [2:0] k, logic [7:0] ch);
        logic [7:0] t;
        unique case (k)
            3'd0: t = "E";
            3'd1: t = "N";
            3'd2: t = "E";
            3'd3: t = "R";
            3'd4: t = "G";
            3'd5: t = "Y";
            default: t = ":";
        endcase
        if (ch == t) return k + 3'd1;
        if (k == 3'd3 && ch == "N") return 3'd2;
        return (ch == "E") ? 3'd1 : 3'd0;
    endfunction

    always_comb begin
        c      = i_rx_byte;
        dig    = (c >= "0") && (c <= "9");
        dv     = 4'(c - 8'h30);
        id_mul = {4'd0, r_id} * 36'd10 + {32'd0, dv};
        e_int  = {4'd0, r_energy} * 20'd10 + 20'(dv) * 20'd100;
        e_add  = {1'b0, r_energy} + ((r_phase == PH_E_FR1) ? 17'(dv) * 17'd10 : 17'(dv));

        n_count  = r_count;
        n_phase  = r_phase;
        n_id     = r_id;
        n_tag    = r_tag;
        n_energy = r_energy;
        n_alarm  = r_alarm;
        n_emit   = 1'b0;
        n_cmd    = '0;
        n_cmd.local_energy = (i_local_energy > 14'd10000) ? 14'd10000 : i_local_energy;

        if (i_req_type) begin
            n_emit     = 1'b1;
            n_cmd.kind = CMD_TICK;
        end else if (c == 8'h0A) begin
            n_emit           = 1'b1;
            n_cmd.id         = r_id;
            n_cmd.alarm      = r_alarm;
            n_cmd.energy     = r_energy;
            n_cmd.has_energy = (r_phase >= PH_E_INT) && (r_phase <= PH_E_DONE);
            if (r_phase == PH_ID || r_phase == PH_ID_END)
                n_cmd.kind = CMD_MALFORMED;
            else if (r_phase >= PH_PAYLOAD && r_phase <= PH_E_DONE)
                n_cmd.kind = CMD_DATA_LINE;
            else if (r_phase == PH_ACK_ID || r_phase == PH_ACK_END)
                n_cmd.kind = CMD_ACK_LINE;
            else
                n_cmd.kind = CMD_UNRECOG;
            n_count = '0; n_phase = PH_START; n_id = '0; n_tag = '0;
            n_energy = '0; n_alarm = 1'b0;
        end else if (r_count >= LCNT_W'(LINE_MAX - 1)) begin
            n_emit     = 1'b1;
            n_cmd.kind = CMD_OVERFLOW;
            n_count = '0; n_phase = PH_START; n_id = '0; n_tag = '0;
            n_energy = '0; n_alarm = 1'b0;
        end else begin
            n_count = r_count + LCNT_W'(1);
            unique case (r_phase)
                PH_START: n_phase = (c == "D") ? PH_DATA_P : (c == "A") ? PH_A : PH_JUNK;
                PH_A:     n_phase = (c == "L") ? PH_ALARM_P : (c == "C") ? PH_ACK_P : PH_JUNK;
                PH_DATA_P: begin
                    if ((r_count == LCNT_W'(1) && c == "A") ||
                        (r_count == LCNT_W'(2) && c == "T") ||
                        (r_count == LCNT_W'(3) && c == "A")) begin
                    end else if (r_count == LCNT_W'(4) && c == "|") begin
                        n_phase = PH_ID; n_id = '0; n_alarm = 1'b0;
                    end else n_phase = PH_JUNK;
                end
                PH_ALARM_P: begin
                    if ((r_count == LCNT_W'(2) && c == "A") ||
                        (r_count == LCNT_W'(3) && c == "R") ||
                        (r_count == LCNT_W'(4) && c == "M")) begin
                    end else if (r_count == LCNT_W'(5) && c == "|") begin
                        n_phase = PH_ID; n_id = '0; n_alarm = 1'b1;
                    end else n_phase = PH_JUNK;
                end
                PH_ACK_P: begin
                    if (r_count == LCNT_W'(2) && c == "K") begin
                    end else if (r_count == LCNT_W'(3) && c == "|") begin
                        n_phase = PH_ACK_ID; n_id = '0;
                    end else n_phase = PH_JUNK;
                end
                PH_ID, PH_ID_END: begin
                    if (c == "|") begin
                        n_phase = PH_PAYLOAD; n_tag = '0;
                    end else if (r_phase == PH_ID && dig)
                        n_id = (|id_mul[35:32]) ? 32'hFFFF_FFFF : id_mul[31:0];
                    else n_phase = PH_ID_END;
                end
                PH_PAYLOAD: begin
                    n_tag = energy_search(r_tag, c);
                    if (n_tag == 3'd7) begin
                        n_phase = PH_E_INT; n_energy = '0; n_tag = '0;
                    end
                end
                PH_E_INT: begin
                    if (dig) n_energy = (|e_int[19:16]) ? 16'hFFFF : e_int[15:0];
                    else n_phase = (c == ".") ? PH_E_FR1 : PH_E_DONE;
                end
                PH_E_FR1: begin
                    if (dig) begin
                        n_energy = e_add[16] ? 16'hFFFF : e_add[15:0];
                        n_phase  = PH_E_FR2;
                    end else n_phase = PH_E_DONE;
                end
                PH_E_FR2: begin
                    if (dig) n_energy = e_add[16] ? 16'hFFFF : e_add[15:0];
                    n_phase = PH_E_DONE;
                end
                PH_ACK_ID: begin
                    if (dig) n_id = (|id_mul[35:32]) ? 32'hFFFF_FFFF : id_mul[31:0];
                    else n_phase = PH_ACK_END;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0; r_phase <= PH_START; r_id <= '0; r_tag <= '0;
            r_energy <= '0; r_alarm <= 1'b0; r_cv <= 1'b0;
        end else begin
            if (i_valid && o_ready) begin
                r_count <= n_count; r_phase <= n_phase; r_id <= n_id;
                r_tag <= n_tag; r_energy <= n_energy; r_alarm <= n_alarm;
                r_cv  <= n_emit;
                if (n_emit) r_cmd <= n_cmd;
            end else if (i_cmd_ready) begin
                r_cv <= 1'b0;
            end
        end
    end

endmodule
`default_nettype wire

// ===== hw/rtl/llsw_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// llsw_back: link engine
// Takes one command at a time: history compare in S_CMP, then commit and
// result in S_EXEC. Holds history, remote energy, own id and tick counters.
// ----------------------------------------------------------------------------
module llsw_back import llsw_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cmd_valid,
    output logic             o_cmd_ready,
    input  wire t_cmd        i_cmd,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_idx,
    input  wire logic [15:0] i_cfg_data,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [58:0]      o_data
);

    typedef enum logic { S_CMP, S_EXEC } t_state;

    t_state r_state;
    logic [15:0] r_interval, r_timeout;
    logic [13:0] r_min_e, r_fall;
    logic [31:0] r_hist [HISTORY_DEPTH];
    logic [FILL_W-1:0] r_fill;
    logic [HIST_W-1:0] r_slot;
    logic r_known, r_await, r_dup, r_ov;
    logic [15:0] r_renergy, r_rel, r_snd;
    logic signed [16:0] r_trend;
    logic [31:0] r_own;
    logic [58:0] r_od;
    t_cmd r_cmd;

    logic hit;
    logic [15:0] rel_inc, snd_inc;
    logic fav;

    assign o_cmd_ready = (r_state == S_CMP) && !r_ov;
    assign o_valid     = r_ov;
    assign o_data      = r_od;

    always_comb begin
        hit = 1'b0;
        for (int i = 0; i < HISTORY_DEPTH; i++)
            if (FILL_W'(i) < r_fill && r_hist[i] == i_cmd.id) hit = 1'b1;
        rel_inc = (r_rel == 16'hFFFF) ? r_rel : r_rel + 16'd1;
        snd_inc = (r_snd == 16'hFFFF) ? r_snd : r_snd + 16'd1;
        fav = 1'b1;
        if (r_cmd.local_energy < r_min_e) fav = 1'b0;
        else if (r_known && r_renergy < {2'b0, r_min_e} &&
                 r_trend < -$signed({3'b0, r_fall})) fav = 1'b0;
    end

    // result packing: event (low bits, goes to tuser), then id, alarm, dup,
    // retry, energy
    function automatic logic [58:0] pack(logic [2:0] ev, logic [31:0] id, logic al,
                                         logic dp, logic rt, logic [13:0] en);
        return {7'd0, en, rt, dp, al, id, ev};
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CMP; r_interval <= 16'd2000; r_timeout <= 16'd1000;
            r_min_e <= 14'd2000; r_fall <= 14'd100; r_fill <= '0; r_slot <= '0;
            r_known <= 1'b0; r_await <= 1'b0; r_ov <= 1'b0; r_renergy <= '0;
            r_rel <= '0; r_snd <= '0; r_trend <= '0; r_own <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    REG_SEND_INTERVAL: r_interval <= i_cfg_data;
                    REG_ACK_TIMEOUT:   r_timeout  <= i_cfg_data;
                    REG_MIN_ENERGY:    r_min_e    <= i_cfg_data[13:0];
                    REG_FALL_THRESH:   r_fall     <= i_cfg_data[13:0];
                endcase
            end
            if (r_ov && i_ready) r_ov <= 1'b0;
            unique case (r_state)
                S_CMP: if (i_cmd_valid && o_cmd_ready) begin
                    r_cmd <= i_cmd; r_dup <= hit; r_state <= S_EXEC;
                end
                S_EXEC: begin
                    r_state <= S_CMP;
                    unique case (r_cmd.kind)
                        CMD_TICK: begin
                            r_rel <= rel_inc;
                            if (!r_await) begin
                                if (rel_inc >= r_interval && fav) begin
                                    r_await <= 1'b1; r_snd <= '0; r_ov <= 1'b1;
                                    r_od <= pack(EV_DATA, r_own, 1'b0, 1'b0, 1'b0,
                                                 r_cmd.local_energy);
                                end else r_snd <= snd_inc;
                            end else if (snd_inc >= r_timeout) begin
                                r_snd <= '0; r_ov <= 1'b1;
                                r_od <= pack(EV_DATA, r_own, 1'b0, 1'b0, 1'b1,
                                             r_cmd.local_energy);
                            end else r_snd <= snd_inc;
                        end
                        CMD_DATA_LINE: begin
                            r_ov <= 1'b1;
                            r_od <= pack(EV_ACK, r_cmd.id, r_cmd.alarm, r_dup, 1'b0, 14'd0);
                            if (!r_dup) begin
                                if (r_cmd.has_energy) begin
                                    if (r_known)
                                        r_trend <= $signed({1'b0, r_cmd.energy}) -
                                                   $signed({1'b0, r_renergy});
                                    r_renergy <= r_cmd.energy; r_known <= 1'b1;
                                end
                                r_hist[r_slot] <= r_cmd.id;
                                r_slot <= (r_slot == HIST_W'(HISTORY_DEPTH - 1)) ?
                                          '0 : r_slot + HIST_W'(1);
                                if (r_fill < FILL_W'(HISTORY_DEPTH))
                                    r_fill <= r_fill + FILL_W'(1);
                            end
                        end
                        CMD_ACK_LINE: begin
                            r_ov <= 1'b1;
                            if (r_await && r_cmd.id == r_own) begin
                                r_own <= r_own + 32'd1; r_await <= 1'b0; r_rel <= '0;
                                r_od <= pack(EV_OWN_ACK, r_cmd.id, 1'b0, 1'b0, 1'b0, 14'd0);
                            end else
                                r_od <= pack(EV_ACK_IGN, r_cmd.id, 1'b0, 1'b0, 1'b0, 14'd0);
                        end
                        CMD_MALFORMED: begin
                            r_ov <= 1'b1;
                            r_od <= pack(EV_MALFORMED, 32'd0, 1'b0, 1'b0, 1'b0, 14'd0);
                        end
                        CMD_OVERFLOW: begin
                            r_ov <= 1'b1;
                            r_od <= pack(EV_OVERFLOW, 32'd0, 1'b0, 1'b0, 1'b0, 14'd0);
                        end
                        default: begin
                            r_ov <= 1'b1;
                            r_od <= pack(EV_UNRECOG, 32'd0, 1'b0, 1'b0, 1'b0, 14'd0);
                        end
                    endcase
                end
            endcase
        end
    end

endmodule
`default_nettype wire

// ===== hw/rtl/line_link_stop_and_wait_engine_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// line_link_stop_and_wait_engine_unit: line-based stop-and-wait link engine
// Parses received text lines and millisecond ticks; answers data lines,
// releases own packets on ack, and schedules own sends and retries.
// ----------------------------------------------------------------------------
// channel  dir  payload
// s_axis   in   tdata[7:0] rx_byte, [21:8] local_energy; tuser req_type
// m_axis   out  tdata[31:0] packet_id, [32] is_alarm, [33] duplicate,
//               [34] is_retry, [48:35] energy_report; tuser[2:0] event_res
// cfg      in   we, idx[1:0], data[15:0]
//
// Bytes with no result are taken every cycle unless a command waits untaken.
// A line end, overflow or tick becomes a command in a one-deep register; the
// engine compares the history as it takes a command and commits in the next
// cycle; a result then waits for its m_axis transfer before the next command
// is taken. Synchronous active-low reset; the history needs no clearing pass.
// A stalled m_axis holds the engine; the parser keeps taking bytes until
// its command register is full.
// ----------------------------------------------------------------------------
module line_link_stop_and_wait_engine_unit import llsw_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [23:0] s_axis_tdata,   // rx_byte, local_energy
    input  wire logic        s_axis_tuser,   // req_type
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [55:0]      m_axis_tdata,   // packet_id, is_alarm, duplicate,
                                             // is_retry, energy_report
    output logic [2:0]       m_axis_tuser,   // event_res
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_idx,
    input  wire logic [15:0] i_cfg_data
);

    logic cmd_valid, cmd_ready;
    t_cmd cmd;
    logic [58:0] od;

    llsw_front u_front (
        .i_clk, .i_rst_n,
        .i_valid(s_axis_tvalid), .o_ready(s_axis_tready),
        .i_req_type(s_axis_tuser), .i_rx_byte(s_axis_tdata[7:0]),
        .i_local_energy(s_axis_tdata[21:8]),
        .o_cmd_valid(cmd_valid), .o_cmd(cmd), .i_cmd_ready(cmd_ready)
    );

    llsw_back u_back (
        .i_clk, .i_rst_n,
        .i_cmd_valid(cmd_valid), .o_cmd_ready(cmd_ready), .i_cmd(cmd),
        .i_cfg_we, .i_cfg_idx, .i_cfg_data,
        .o_valid(m_axis_tvalid), .i_ready(m_axis_tready), .o_data(od)
    );

    assign m_axis_tuser = od[2:0];
    assign m_axis_tdata = od[58:3];

endmodule
`default_nettype wire

// ===== dv/line_link_stop_and_wait_engine_unit_tb.sv =====
// ----------------------------------------------------------------------------
// line_link_stop_and_wait_engine_unit_tb: self-checking bench for the engine
// Sends text lines and millisecond ticks over s_axis and keeps its own model
// of the line parser, id history and send scheduler. Every m_axis transfer is
// compared field by field with the oldest predicted event.
// ----------------------------------------------------------------------------
module line_link_stop_and_wait_engine_unit_tb;
    import llsw_pkg::*;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata;   // rx_byte, local_energy
    logic        s_axis_tuser;   // req_type
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [55:0] m_axis_tdata;   // packet_id, is_alarm, duplicate,
                                 // is_retry, energy_report
    logic [2:0]  m_axis_tuser;   // event_res
    logic        i_cfg_we;
    logic [1:0]  i_cfg_idx;
    logic [15:0] i_cfg_data;

    line_link_stop_and_wait_engine_unit u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        i_clk = 1'b1; #6;
        i_clk = 1'b0; #6;
    end

    // one predicted m_axis transfer
    typedef struct {
        logic [2:0]  ev;
        logic [31:0] id;
        logic        alarm;
        logic        dup;
        logic        retry;
        logic [13:0] energy;
    } t_link_event;

    t_link_event pending_events[$];
    int          errors;
    int          items_sent;

    // link model: configuration
    logic [15:0] cfg_interval, cfg_timeout;
    logic [13:0] cfg_min_energy, cfg_fall;

    // link model: line parser, history, scheduler
    logic [7:0]  ln_count;
    t_phase      ln_phase;
    logic [31:0] ln_id;
    logic [2:0]  ln_tag;
    logic [15:0] ln_energy;
    logic        ln_alarm;
    logic [31:0] id_hist [HISTORY_DEPTH];
    int          hist_fill, hist_slot;
    logic        far_known;
    logic [15:0] far_energy;
    int          far_trend;
    logic        in_flight;
    logic [31:0] my_id;
    logic [15:0] ticks_released, ticks_sent;

    // flow control knobs
    bit tx_idle_on, rx_idle_on, rx_hold_req;
    int rx_wait;

    function automatic void clear_line();
        ln_count  = '0;
        ln_phase  = PH_START;
        ln_id     = '0;
        ln_tag    = '0;
        ln_energy = '0;
        ln_alarm  = 1'b0;
    endfunction

    function automatic void link_reset();
        cfg_interval   = 16'd2000;
        cfg_timeout    = 16'd1000;
        cfg_min_energy = 14'd2000;
        cfg_fall       = 14'd100;
        clear_line();
        hist_fill      = 0;
        hist_slot      = 0;
        far_known      = 1'b0;
        far_energy     = '0;
        far_trend      = 0;
        in_flight      = 1'b0;
        my_id          = '0;
        ticks_released = '0;
        ticks_sent     = '0;
    endfunction

    function automatic void post_event(logic [2:0] ev, logic [31:0] id, logic alarm,
                                       logic dup, logic retry, logic [13:0] en);
        t_link_event e;
        e.ev = ev; e.id = id; e.alarm = alarm; e.dup = dup; e.retry = retry;
        e.energy = en;
        pending_events.push_back(e);
    endfunction

    function automatic logic [31:0] add_digit(logic [31:0] acc, logic [7:0] c);
        logic [63:0] t;
        t = acc * 64'd10 + (c - 8'd48);
        return (t > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : t[31:0];
    endfunction

    function automatic bit is_num(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic void parse_kept_byte(logic [7:0] c, int pos);
        string data_pfx, alarm_pfx, ack_pfx, tag;
        int    t;
        data_pfx = "DATA|"; alarm_pfx = "ALARM|"; ack_pfx = "ACK|"; tag = "ENERGY:";
        case (ln_phase)
            PH_START: ln_phase = (c == "D") ? PH_DATA_P : (c == "A") ? PH_A : PH_JUNK;
            PH_A:     ln_phase = (c == "L") ? PH_ALARM_P : (c == "C") ? PH_ACK_P : PH_JUNK;
            PH_DATA_P: begin
                if (pos < 5 && c == data_pfx[pos]) begin
                    if (pos == 4) begin ln_phase = PH_ID; ln_id = '0; ln_alarm = 1'b0; end
                end else ln_phase = PH_JUNK;
            end
            PH_ALARM_P: begin
                if (pos < 6 && c == alarm_pfx[pos]) begin
                    if (pos == 5) begin ln_phase = PH_ID; ln_id = '0; ln_alarm = 1'b1; end
                end else ln_phase = PH_JUNK;
            end
            PH_ACK_P: begin
                if (pos < 4 && c == ack_pfx[pos]) begin
                    if (pos == 3) begin ln_phase = PH_ACK_ID; ln_id = '0; end
                end else ln_phase = PH_JUNK;
            end
            PH_ID, PH_ID_END: begin
                if (c == "|") begin
                    ln_phase = PH_PAYLOAD; ln_tag = '0;
                end else if (ln_phase == PH_ID && is_num(c)) ln_id = add_digit(ln_id, c);
                else ln_phase = PH_ID_END;
            end
            PH_PAYLOAD: begin
                // sliding match of the energy tag; "ENENERGY:" must still hit
                if (ln_tag < 7 && c == tag[ln_tag]) t = ln_tag + 1;
                else if (ln_tag == 3 && c == "N") t = 2;
                else t = (c == "E") ? 1 : 0;
                if (t >= 7) begin
                    ln_phase = PH_E_INT; ln_energy = '0; ln_tag = '0;
                end else ln_tag = 3'(t);
            end
            PH_E_INT: begin
                if (is_num(c)) begin
                    t = ln_energy * 10 + (c - 48) * 100;
                    ln_energy = (t > 65535) ? 16'hFFFF : 16'(t);
                end else ln_phase = (c == ".") ? PH_E_FR1 : PH_E_DONE;
            end
            PH_E_FR1: begin
                if (is_num(c)) begin
                    t = ln_energy + (c - 48) * 10;
                    ln_energy = (t > 65535) ? 16'hFFFF : 16'(t);
                    ln_phase = PH_E_FR2;
                end else ln_phase = PH_E_DONE;
            end
            PH_E_FR2: begin
                if (is_num(c)) begin
                    t = ln_energy + (c - 48);
                    ln_energy = (t > 65535) ? 16'hFFFF : 16'(t);
                end
                ln_phase = PH_E_DONE;
            end
            PH_ACK_ID: begin
                if (is_num(c)) ln_id = add_digit(ln_id, c);
                else ln_phase = PH_ACK_END;
            end
            default: ;
        endcase
    endfunction

    function automatic void close_line();
        bit seen;
        seen = 0;
        if (ln_phase == PH_ID || ln_phase == PH_ID_END) begin
            post_event(EV_MALFORMED, '0, 0, 0, 0, '0);
        end else if (ln_phase >= PH_PAYLOAD && ln_phase <= PH_E_DONE) begin
            for (int i = 0; i < hist_fill; i++) if (id_hist[i] == ln_id) seen = 1;
            if (seen) begin
                post_event(EV_ACK, ln_id, ln_alarm, 1, 0, '0);
            end else begin
                if (ln_phase >= PH_E_INT) begin
                    if (far_known) far_trend = int'(ln_energy) - int'(far_energy);
                    far_energy = ln_energy;
                    far_known  = 1'b1;
                end
                id_hist[hist_slot] = ln_id;
                hist_slot = (hist_slot + 1) % HISTORY_DEPTH;
                if (hist_fill < HISTORY_DEPTH) hist_fill++;
                post_event(EV_ACK, ln_id, ln_alarm, 0, 0, '0);
            end
        end else if (ln_phase == PH_ACK_ID || ln_phase == PH_ACK_END) begin
            if (in_flight && ln_id == my_id) begin
                post_event(EV_OWN_ACK, ln_id, 0, 0, 0, '0);
                my_id++;
                in_flight = 1'b0;
                ticks_released = '0;
            end else post_event(EV_ACK_IGN, ln_id, 0, 0, 0, '0);
        end else post_event(EV_UNRECOG, '0, 0, 0, 0, '0);
        clear_line();
    endfunction

    // advance the link model by one accepted transfer
    function automatic void predict_link(logic tick, logic [7:0] rx, logic [13:0] le_in);
        logic [13:0] le;
        bit          ok;
        if (!tick) begin
            if (rx == 8'h0A) close_line();
            else if (ln_count < LINE_MAX - 1) begin
                ln_count++;
                parse_kept_byte(rx, ln_count - 1);
            end else begin
                clear_line();
                post_event(EV_OVERFLOW, '0, 0, 0, 0, '0);
            end
        end else begin
            le = (le_in > 14'd10000) ? 14'd10000 : le_in;
            if (ticks_released != 16'hFFFF) ticks_released++;
            if (ticks_sent != 16'hFFFF) ticks_sent++;
            if (!in_flight) begin
                ok = le >= cfg_min_energy;
                if (ok && far_known && far_energy < cfg_min_energy
                    && far_trend < -int'(cfg_fall)) ok = 0;
                if (ticks_released >= cfg_interval && ok) begin
                    in_flight  = 1'b1;
                    ticks_sent = '0;
                    post_event(EV_DATA, my_id, 0, 0, 0, le);
                end
            end else if (ticks_sent >= cfg_timeout) begin
                ticks_sent = '0;
                post_event(EV_DATA, my_id, 0, 0, 1, le);
            end
        end
    endfunction

    // ---------------------------------------------------------------- drivers
    // Entered at a falling edge; returns at the falling edge after the transfer.
    task automatic send_item(logic tick, logic [7:0] rx, logic [13:0] le);
        int gap;
        gap = tx_idle_on ? $urandom_range(0, 5) : 0;
        if (gap > 0) begin
            s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tuser  = tick;
        s_axis_tdata  = {2'b00, le, rx};
        do @(posedge i_clk); while (!s_axis_tready);
        predict_link(tick, rx, le);
        items_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_byte(logic [7:0] b);
        send_item(1'b0, b, 14'($urandom_range(0, 16383)));
    endtask

    task automatic send_text(string s);
        for (int i = 0; i < s.len(); i++) send_byte(s[i]);
    endtask

    task automatic send_line(string s);
        send_text(s);
        send_byte(8'h0A);
    endtask

    task automatic send_tick(logic [13:0] le);
        send_item(1'b1, 8'($urandom_range(0, 255)), le);
    endtask

    // pause the sender until every predicted event has come out
    task automatic drain();
        s_axis_tvalid = 1'b0;
        while (pending_events.size() != 0) @(negedge i_clk);
        repeat (10) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [15:0] val);
        i_cfg_we = 1'b1; i_cfg_idx = idx; i_cfg_data = val;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        case (idx)
            REG_SEND_INTERVAL: cfg_interval   = val;
            REG_ACK_TIMEOUT:   cfg_timeout    = val;
            REG_MIN_ENERGY:    cfg_min_energy = val[13:0];
            REG_FALL_THRESH:   cfg_fall       = val[13:0];
            default: ;
        endcase
    endtask

    task automatic set_link(logic [15:0] iv, logic [15:0] to, logic [15:0] me,
                            logic [15:0] ft);
        drain();
        write_reg(REG_SEND_INTERVAL, iv);
        write_reg(REG_ACK_TIMEOUT, to);
        write_reg(REG_MIN_ENERGY, me);
        write_reg(REG_FALL_THRESH, ft);
    endtask

    // ------------------------------------------------------------- receiver
    always @(negedge i_clk) begin
        if (rx_hold_req) begin
            // long hold-off, counted here while the sender keeps offering
            rx_hold_req = 0;
            m_axis_tready = 1'b0;
            repeat (400) @(negedge i_clk);
        end
        if (rx_wait > 0) begin
            m_axis_tready = 1'b0;
            rx_wait--;
        end else m_axis_tready = 1'b1;
    end

    function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s: expected %0d, got %0d", name, exp_v, act_v);
            errors++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_link_event e;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            rx_wait = rx_idle_on ? $urandom_range(0, 5) : 0;
            if (pending_events.size() == 0) begin
                $error("event_res: no event expected, got %0d", m_axis_tuser);
                errors++;
            end else begin
                e = pending_events.pop_front();
                check_field("event_res", e.ev, m_axis_tuser);
                check_field("packet_id", e.id, m_axis_tdata[31:0]);
                check_field("is_alarm", e.alarm, m_axis_tdata[32]);
                check_field("duplicate", e.dup, m_axis_tdata[33]);
                check_field("is_retry", e.retry, m_axis_tdata[34]);
                check_field("energy_report", e.energy, m_axis_tdata[48:35]);
            end
        end
    end

    // ------------------------------------------------------------ stimulus
    function automatic string rand_text(int n);
        string s;
        s = "";
        for (int i = 0; i < n; i++) s = {s, string'(byte'($urandom_range(32, 126)))};
        return s;
    endfunction

    function automatic logic [13:0] rand_energy();
        return ($urandom_range(0, 7) == 0) ? 14'($urandom_range(0, 16383))
                                           : 14'($urandom_range(0, 10000));
    endfunction

    task automatic test_directed();
        string ovf;
        set_link(16'd1, 16'd2, 16'd0, 16'd0);
        send_line("DATA|5|hello");
        send_line("ALARM|4294967296|ENERGY:12.345");   // id saturates, fraction cut
        send_line("DATA|5|again");                     // duplicate
        send_line("DATA|7");                           // no separator
        send_line("ALARM|x9|p");                       // id ends early
        send_line("HELLO");
        send_line("");
        send_line("ACK|0");                            // nothing in flight
        send_line("DATA|8|ENENERGY:99999.9\r");        // overlapped tag, saturates
        send_text("DATA|9|");                          // zero byte inside the payload
        send_byte(8'h00);
        send_line("ENERGY:.5");
        send_line("DATA|10|ENERGY:");                  // empty value still counts
        send_tick(14'd16383);                          // own send, energy clipped
        send_tick(14'd0);
        send_tick(14'd0);                              // retry on timeout
        send_line("ACK|1");                            // wrong id
        send_line("ACK|0\r");                          // releases
        send_tick(14'd5000);
        ovf = "";
        for (int i = 0; i < LINE_MAX; i++) ovf = {ovf, "Z"};
        send_line(ovf);                                // overflow then empty line
    endtask

    task automatic test_window();
        // low falling remote energy blocks the send until a rising report
        set_link(16'd1, 16'd65535, 16'd10000, 16'd0);
        send_line("DATA|100|ENERGY:90");
        send_line("DATA|101|ENERGY:80");
        send_tick(14'd10000);
        send_line("DATA|102|ENERGY:85");
        send_tick(14'd10000);
        send_line("ACK|1");
        set_link(16'd65535, 16'd1, 16'd10000, 16'd10000);
        repeat (3) send_tick(14'd12000);
    endtask

    task automatic random_line();
        string s;
        int    k;
        k = $urandom_range(0, 11);
        case (k)
            0, 1, 2, 3: begin
                s = ($urandom_range(0, 2) == 0) ? "ALARM|" : "DATA|";
                case ($urandom_range(0, 3))
                    0: s = {s, $sformatf("%0d", $urandom())};
                    1: s = {s, "99999999999"};
                    default: s = {s, $sformatf("%0d", $urandom_range(0, 12))};
                endcase
                if ($urandom_range(0, 7) == 0) s = {s, rand_text(2)};
                if ($urandom_range(0, 9) != 0) begin
                    s = {s, "|", rand_text($urandom_range(0, 6))};
                    if ($urandom_range(0, 2) != 0)
                        s = {s, ($urandom_range(0, 3) == 0) ? "ENENERGY:" : "ENERGY:",
                             $sformatf("%0d", $urandom_range(0, 120)),
                             ($urandom_range(0, 1) ? $sformatf(".%0d", $urandom_range(0, 999))
                                                   : ""),
                             rand_text($urandom_range(0, 3))};
                end
                if ($urandom_range(0, 5) == 0) s = {s, "\r"};
                send_line(s);
            end
            4, 5: send_line($sformatf("ACK|%0d", (in_flight && $urandom_range(0, 3) != 0)
                                                  ? my_id : $urandom_range(0, 20)));
            6, 7, 8: repeat ($urandom_range(1, 6)) send_tick(rand_energy());
            9: begin
                repeat ($urandom_range(0, 10)) send_byte(8'($urandom_range(0, 255)));
                send_byte(8'h0A);
            end
            10: send_line(rand_text($urandom_range(0, 12)));
            default: repeat ($urandom_range(0, 140)) send_byte("D");
        endcase
    endtask

    task automatic test_random();
        int target;
        target = items_sent + 270;
        while (items_sent < target) begin
            tx_idle_on = $urandom_range(0, 3) != 0;
            rx_idle_on = $urandom_range(0, 3) != 0;
            if ($urandom_range(0, 14) == 0)
                set_link($urandom_range(0, 5) == 0 ? 16'd65535 : 16'($urandom_range(1, 30)),
                         $urandom_range(0, 5) == 0 ? 16'd65535 : 16'($urandom_range(1, 30)),
                         16'($urandom_range(0, 2) * 5000),
                         $urandom_range(0, 1) ? 16'd10000 : 16'($urandom_range(0, 500)));
            random_line();
        end
    endtask

    task automatic test_backpressure();
        rx_hold_req = 1;
        tx_idle_on  = 0;
        for (int i = 0; i < 10; i++) send_line($sformatf("DATA|%0d|x", 500 + i));
        drain();
        tx_idle_on = 1;
    endtask

    initial begin
        errors        = 0;
        items_sent    = 0;
        tx_idle_on    = 1;
        rx_idle_on    = 1;
        rx_hold_req   = 0;
        rx_wait       = 0;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tuser  = 1'b0;
        s_axis_tdata  = '0;
        m_axis_tready = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_idx     = REG_SEND_INTERVAL;
        i_cfg_data    = '0;
        link_reset();
        repeat (5) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        test_directed();
        test_window();
        test_backpressure();
        set_link(16'd3, 16'd5, 16'd2000, 16'd100);
        test_random();

        drain();
        if (errors == 0) $display("simulation ok");
        else $display("simulation failed");
        $finish;
    end

    initial begin
        #(12 * 2000000);
        $display("simulation failed");
        $finish;
    end

endmodule
